[sv/csu_pkg.sv]
// Shared constants and control types for the cosine similarity unit.
package csu_pkg;

	localparam int FIELD_BITS   = 16;  // width of each element field on the input stream
	localparam int ELEMENT_BITS = 16;  // default count of element bits taken from each field
	localparam int ACC_BITS     = 43;  // accumulator width, saturating
	localparam int PROD_BITS    = 2 * ACC_BITS;
	localparam int FRAC_SHIFT   = 32;  // 2^32 scale on dot^2 for a Q16 quotient
	localparam int WIDE_BITS    = 120; // width of the square-root search words
	localparam int SIM_BITS     = 17;  // Q1.16 similarity
	localparam int SEARCH_TOP   = 16;  // first quotient bit tried
	localparam int BIT_IDX_BITS = 5;
	localparam int MUL_CHUNK    = 11;  // multiplier operand slice per step
	localparam int MUL_STEPS    = 4;
	localparam int MUL_IDX_BITS = 2;

	typedef struct packed {
		logic                    in_take;
		logic                    acc_clear;
		logic                    mul_load_p;
		logic                    mul_load_d;
		logic                    mul_step;
		logic [MUL_IDX_BITS-1:0] mul_idx;
		logic                    search_init;
		logic                    search_add;
		logic                    search_test;
		logic [BIT_IDX_BITS-1:0] search_bit;
		logic                    out_load;
		logic                    out_degen;
	} csu_cmd_t;

	typedef struct packed {
		logic degen;
		logic pass;
	} csu_status_t;

endpackage

[sv/cosine_similarity_unit.sv]
// Top level of the cosine similarity unit: stream ports, controller and datapath.
//
// Input stream (s_*): one transfer per element pair. s_tdata carries element_a and
// element_b, s_tuser the two vector-valid flags, s_tlast marks the final pair.
// Element pairs are taken one per cycle while a vector is being accumulated.
// Output stream (m_*): one transfer per vector, the Q1.16 similarity in m_tdata and
// the degenerate flag in m_tuser.
// After the last pair, s_tready stays low while the result is computed: a degenerate
// result goes straight to the output register; otherwise two sliced 43x43-bit
// products, a setup step and a test per quotient bit (17 bits, fewer when the
// result is exactly 1.0).
// The result waits in an output register; a stalled receiver holds m_tvalid and the
// payload steady, and the next vector may stream in meanwhile. If a second result is
// ready before the first is taken, the unit waits with s_tready low.
// Reset clears the accumulators and all control state, leaving no result pending.
module cosine_similarity_unit #(
	parameter int ELEMENT_BITS = csu_pkg::ELEMENT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] element_a, [31:16] element_b
	input  logic [1:0]  s_tuser,  // [0] first_valid, [1] second_valid
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [16:0] similarity, [23:17] zero
	output logic        m_tuser   // [0] degenerate
);

	csu_pkg::csu_cmd_t             cmd;
	csu_pkg::csu_status_t          status;
	logic [csu_pkg::SIM_BITS-1:0]  similarity;

	csu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.status    (status),
		.cmd       (cmd)
	);

	csu_datapath #(
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.element_a    (s_tdata[15:0]),
		.element_b    (s_tdata[31:16]),
		.first_valid  (s_tuser[0]),
		.second_valid (s_tuser[1]),
		.last_element (s_tlast),
		.similarity   (similarity),
		.degenerate   (m_tuser)
	);

	assign m_tdata = {7'b0, similarity};

endmodule

[sv/csu_ctrl.sv]
// Sequencer for accumulation, the two wide products, the root search and the result hand-off.
module csu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tlast,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  csu_pkg::csu_status_t status,
	output csu_pkg::csu_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DRAIN,
		ST_CHECK,
		ST_MUL_P,
		ST_LOAD_D,
		ST_MUL_D,
		ST_INIT,
		ST_SRCH_A,
		ST_SRCH_B,
		ST_FINISH
	} state_t;

	state_t                                state_q;
	logic [csu_pkg::MUL_IDX_BITS-1:0]      idx_q;
	logic [csu_pkg::BIT_IDX_BITS-1:0]      bit_q;
	logic                                  degen_q;
	logic                                  out_valid_q;
	logic                                  out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_ACCUM);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.in_take     = in_ready && s_tvalid;
		cmd.mul_idx     = idx_q;
		cmd.search_bit  = bit_q;
		cmd.out_degen   = degen_q;
		cmd.mul_load_p  = (state_q == ST_CHECK) && !status.degen;
		cmd.mul_load_d  = (state_q == ST_LOAD_D);
		cmd.mul_step    = (state_q == ST_MUL_P) || (state_q == ST_MUL_D);
		cmd.search_init = (state_q == ST_INIT);
		cmd.search_add  = (state_q == ST_SRCH_A);
		cmd.search_test = (state_q == ST_SRCH_B);
		cmd.out_load    = (state_q == ST_FINISH) && out_free;
		cmd.acc_clear   = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			idx_q       <= '0;
			bit_q       <= '0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCUM: begin
					if (s_tvalid && s_tlast) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					idx_q <= '0;
					if (status.degen) begin
						degen_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						degen_q <= 1'b0;
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == csu_pkg::MUL_IDX_BITS'(csu_pkg::MUL_STEPS - 1)) begin
						state_q <= ST_LOAD_D;
					end
				end
				ST_LOAD_D: begin
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == csu_pkg::MUL_IDX_BITS'(csu_pkg::MUL_STEPS - 1)) begin
						bit_q   <= csu_pkg::BIT_IDX_BITS'(csu_pkg::SEARCH_TOP);
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					state_q <= ST_SRCH_A;
				end
				ST_SRCH_A: begin
					state_q <= ST_SRCH_B;
				end
				ST_SRCH_B: begin
					// A full-scale quotient is the largest allowed, so stop once it passes.
					if ((status.pass && bit_q == csu_pkg::BIT_IDX_BITS'(csu_pkg::SEARCH_TOP))
					    || bit_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= ST_SRCH_A;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

endmodule

[sv/csu_datapath.sv]
// Accumulators, sliced wide multiplier, shift-add root search and the result register.
module csu_datapath #(
	parameter int ELEMENT_BITS = csu_pkg::ELEMENT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  csu_pkg::csu_cmd_t                 cmd,
	output csu_pkg::csu_status_t              status,
	input  logic [csu_pkg::FIELD_BITS-1:0]    element_a,
	input  logic [csu_pkg::FIELD_BITS-1:0]    element_b,
	input  logic                              first_valid,
	input  logic                              second_valid,
	input  logic                              last_element,
	output logic [csu_pkg::SIM_BITS-1:0]      similarity,
	output logic                              degenerate
);

	localparam int USED_BITS = (ELEMENT_BITS < csu_pkg::FIELD_BITS) ? ELEMENT_BITS
	                                                               : csu_pkg::FIELD_BITS;
	localparam int SQ_BITS   = 2 * USED_BITS;
	localparam int ACC_BITS  = csu_pkg::ACC_BITS;
	localparam int PROD_BITS = csu_pkg::PROD_BITS;
	localparam int WIDE_BITS = csu_pkg::WIDE_BITS;
	localparam int CHUNK     = csu_pkg::MUL_CHUNK;
	localparam int MY_BITS   = CHUNK * csu_pkg::MUL_STEPS;
	localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

	logic [USED_BITS-1:0] ea;
	logic [USED_BITS-1:0] eb;
	logic [SQ_BITS-1:0]   prod_ab_s1;
	logic [SQ_BITS-1:0]   prod_aa_s1;
	logic [SQ_BITS-1:0]   prod_bb_s1;
	logic                 valid_s1;
	logic                 both_valid_q;

	logic [ACC_BITS-1:0]  dot_q;
	logic [ACC_BITS-1:0]  sa_q;
	logic [ACC_BITS-1:0]  sb_q;
	logic [ACC_BITS:0]    dot_sum;
	logic [ACC_BITS:0]    sa_sum;
	logic [ACC_BITS:0]    sb_sum;

	logic [ACC_BITS-1:0]        mx_q;
	logic [MY_BITS-1:0]         my_q;
	logic [PROD_BITS-1:0]       mp_q;
	logic [PROD_BITS-1:0]       p_q;
	logic [CHUNK-1:0]           chunk;
	logic [ACC_BITS+CHUNK-1:0]  partial;
	logic [PROD_BITS-1:0]       partial_ext;

	logic [WIDE_BITS-1:0]        r_q;
	logic [WIDE_BITS-1:0]        t_q;
	logic [WIDE_BITS-1:0]        v_q;
	logic [WIDE_BITS-1:0]        w_q;
	logic [WIDE_BITS-1:0]        tmp_q;
	logic [WIDE_BITS-1:0]        cand;
	logic [csu_pkg::SIM_BITS-1:0] q_q;

	logic [csu_pkg::SIM_BITS-1:0] sim_q;
	logic                         degen_q;

	assign ea = element_a[USED_BITS-1:0];
	assign eb = element_b[USED_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			prod_ab_s1 <= ea * eb;
			prod_aa_s1 <= ea * ea;
			prod_bb_s1 <= eb * eb;
			if (last_element) begin
				both_valid_q <= first_valid && second_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.in_take;
		end
	end

	assign dot_sum = {1'b0, dot_q} + (ACC_BITS+1)'(prod_ab_s1);
	assign sa_sum  = {1'b0, sa_q} + (ACC_BITS+1)'(prod_aa_s1);
	assign sb_sum  = {1'b0, sb_q} + (ACC_BITS+1)'(prod_bb_s1);

	// Accumulators saturate at all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (cmd.acc_clear) begin
			dot_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
		end else if (valid_s1) begin
			dot_q <= dot_sum[ACC_BITS] ? ACC_MAX : dot_sum[ACC_BITS-1:0];
			sa_q  <= sa_sum[ACC_BITS]  ? ACC_MAX : sa_sum[ACC_BITS-1:0];
			sb_q  <= sb_sum[ACC_BITS]  ? ACC_MAX : sb_sum[ACC_BITS-1:0];
		end
	end

	assign status.degen = !both_valid_q || (sa_q == '0) || (sb_q == '0);

	// The wide product is built from one operand slice per cycle.
	assign chunk       = my_q[CHUNK*cmd.mul_idx +: CHUNK];
	assign partial     = mx_q * chunk;
	assign partial_ext = PROD_BITS'(partial) << (CHUNK * cmd.mul_idx);

	always_ff @(posedge clk) begin
		if (cmd.mul_load_p) begin
			mx_q <= sa_q;
			my_q <= MY_BITS'(sb_q);
			mp_q <= '0;
		end else if (cmd.mul_load_d) begin
			p_q  <= mp_q;
			mx_q <= dot_q;
			my_q <= MY_BITS'(dot_q);
			mp_q <= '0;
		end else if (cmd.mul_step) begin
			mp_q <= mp_q + partial_ext;
		end
	end

	// Bitwise search for the largest q with q^2 * Sa * Sb <= 2^32 * dot^2.
	// T holds q^2 * P, V holds 2 * q * P * 2^k and W holds P * 2^(2k).
	assign cand        = tmp_q + w_q;
	assign status.pass = (cand <= r_q);

	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			r_q <= {2'b00, mp_q, {csu_pkg::FRAC_SHIFT{1'b0}}};
			w_q <= {2'b00, p_q, {csu_pkg::FRAC_SHIFT{1'b0}}};
			t_q <= '0;
			v_q <= '0;
			q_q <= '0;
		end else if (cmd.search_add) begin
			tmp_q <= t_q + v_q;
		end else if (cmd.search_test) begin
			w_q <= w_q >> 2;
			if (status.pass) begin
				t_q             <= cand;
				v_q             <= (v_q >> 1) + w_q;
				q_q[cmd.search_bit] <= 1'b1;
			end else begin
				v_q <= v_q >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sim_q   <= cmd.out_degen ? '0 : q_q;
			degen_q <= cmd.out_degen;
		end
	end

	assign similarity = sim_q;
	assign degenerate = degen_q;

endmodule

[sim/cosine_similarity_unit_tb.sv]
// Self-checking testbench for the cosine similarity unit: directed, long and random vectors.
`timescale 1ns / 100ps

module cosine_similarity_unit_tb;

	localparam int                  SIM_BITS = csu_pkg::SIM_BITS;
	localparam int                  ACC_BITS = csu_pkg::ACC_BITS;
	localparam logic [SIM_BITS-1:0] UNITY    = 17'h10000;
	localparam logic [ACC_BITS-1:0] ACC_MAX  = {ACC_BITS{1'b1}};
	localparam int                  DIR_ROWS = 22;
	localparam int                  HOLD_CYCLES = 600;

	typedef struct packed {
		logic [15:0]         elem_a;
		logic [15:0]         elem_b;
		logic                first_ok;
		logic                second_ok;
		logic                last;
		logic                known;
		logic [SIM_BITS-1:0] sim;
		logic                degen;
	} pair_row_t;

	typedef struct packed {
		logic [SIM_BITS-1:0] sim;
		logic                degen;
	} score_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;

	logic [ACC_BITS-1:0] dot_acc;
	logic [ACC_BITS-1:0] a_energy;
	logic [ACC_BITS-1:0] b_energy;
	score_t              pending_scores [$];
	int                  error_count;
	int                  scores_taken;
	logic                send_steady;
	logic                take_steady;

	// Rows with known set carry a result that is obvious by inspection; the rest
	// are predicted.
	pair_row_t directed [DIR_ROWS] = '{
		// Identical single-element vectors at full scale.
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, UNITY, 1'b0},
		// Both magnitudes zero.
		'{16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
		// Second magnitude zero.
		'{16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
		// First magnitude zero.
		'{16'h0000, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
		// Invalid vectors force a degenerate zero.
		'{16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 17'd0, 1'b1},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 17'd0, 1'b1},
		'{16'h1234, 16'h4321, 1'b0, 1'b0, 1'b1, 1'b1, 17'd0, 1'b1},
		// Orthogonal vectors; valid flags are ignored before the last pair.
		'{16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 17'd0, 1'b0},
		// Smallest nonzero elements.
		'{16'h0001, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b1, UNITY, 1'b0},
		'{16'h0001, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, UNITY, 1'b0},
		// Parallel vectors of different length give exactly one.
		'{16'h8000, 16'h4000, 1'b0, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h2000, 16'h1000, 1'b1, 1'b1, 1'b1, 1'b1, UNITY, 1'b0},
		// Forty-five degrees: floor(65536 / sqrt(2)).
		'{16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h0000, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b1, 17'd46340, 1'b0},
		'{16'hFFFF, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h0001, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0},
		'{16'hAAAA, 16'h5555, 1'b0, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'hFFFF, 16'h7FFF, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0},
		'{16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0, 1'b0},
		'{16'h00FF, 16'hFF00, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0, 1'b0}
	};

	cosine_similarity_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [ACC_BITS-1:0] sat_accumulate(input logic [ACC_BITS-1:0] acc,
			input logic [31:0] prod);
		logic [ACC_BITS:0] sum;
		sum = {1'b0, acc} + {{(ACC_BITS - 31){1'b0}}, prod};
		return (sum >= {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_BITS-1:0];
	endfunction

	// Largest q in 0..1.0 with q^2 * Sa * Sb <= 2^32 * dot^2, by bisection.
	function automatic logic [SIM_BITS-1:0] cosine_q16(input logic [ACC_BITS-1:0] dot,
			input logic [ACC_BITS-1:0] sa, input logic [ACC_BITS-1:0] sb);
		logic [127:0] wa, wb, wd, mag_prod, dot_scaled, q_sq, lhs;
		logic [17:0]  lo, hi, mid;
		wa = 128'(sa);
		wb = 128'(sb);
		wd = 128'(dot);
		mag_prod = wa * wb;
		dot_scaled = (wd * wd) << 32;
		lo = 18'd0;
		hi = 18'(UNITY);
		while (lo < hi) begin
			mid = (lo + hi + 18'd1) >> 1;
			q_sq = 128'(mid) * 128'(mid);
			lhs = q_sq * mag_prod;
			if (lhs <= dot_scaled)
				lo = mid;
			else
				hi = mid - 18'd1;
		end
		return lo[SIM_BITS-1:0];
	endfunction

	task automatic absorb_pair(input pair_row_t row);
		score_t want;
		dot_acc  = sat_accumulate(dot_acc, 32'(row.elem_a) * 32'(row.elem_b));
		a_energy = sat_accumulate(a_energy, 32'(row.elem_a) * 32'(row.elem_a));
		b_energy = sat_accumulate(b_energy, 32'(row.elem_b) * 32'(row.elem_b));
		if (row.last) begin
			want.degen = !row.first_ok || !row.second_ok || a_energy == '0 || b_energy == '0;
			want.sim = want.degen ? '0 : cosine_q16(dot_acc, a_energy, b_energy);
			if (row.known) begin
				want.sim = row.sim;
				want.degen = row.degen;
			end
			pending_scores.push_back(want);
			dot_acc  = '0;
			a_energy = '0;
			b_energy = '0;
		end
	endtask

	// Called at a rising edge; returns at the edge on which the transfer happens.
	task automatic offer_pair(input pair_row_t row);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.elem_b, row.elem_a};
		s_tuser  <= {row.second_ok, row.first_ok};
		s_tlast  <= row.last;
		do @(posedge clk); while (!s_tready);
		absorb_pair(row);
	endtask

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	task automatic send_vector(input int len);
		int          style;
		int          shift;
		logic [16:0] near_b;
		pair_row_t   row;
		style = $urandom_range(0, 5);
		shift = $urandom_range(0, 4);
		for (int i = 0; i < len; i++) begin
			row = '0;
			row.elem_a = 16'($urandom);
			row.elem_b = 16'($urandom);
			case (style)
				1: begin
					near_b = {1'b0, row.elem_a} + 17'($urandom_range(0, 255));
					row.elem_b = near_b[16] ? 16'hFFFF : near_b[15:0];
				end
				2: row.elem_b = row.elem_a >> shift;
				3: begin
					if ($urandom_range(0, 1) == 0)
						row.elem_a = '0;
					if ($urandom_range(0, 1) == 0)
						row.elem_b = '0;
				end
				4: begin
					// One whole vector is zero.
					if (shift[0])
						row.elem_b = '0;
					else
						row.elem_a = '0;
				end
				5: begin
					row.elem_a = corner_value();
					row.elem_b = corner_value();
				end
				default: ;
			endcase
			row.first_ok  = 1'($urandom_range(0, 1));
			row.second_ok = 1'($urandom_range(0, 1));
			row.last      = (i == len - 1);
			if (row.last && $urandom_range(0, 9) != 0) begin
				row.first_ok  = 1'b1;
				row.second_ok = 1'b1;
			end
			offer_pair(row);
		end
	endtask

	// Result side: random stalls, two long hold-offs, and the check of each transfer.
	initial begin
		int     gap;
		score_t want;
		m_tready <= 1'b0;
		take_steady = 1'b0;
		scores_taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (scores_taken == 20 || scores_taken == 90) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 29) == 0)
				take_steady = !take_steady;
			gap = take_steady ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			scores_taken++;
			if (pending_scores.size() == 0) begin
				$error("unexpected result: similarity %0d degenerate %0b",
					m_tdata[SIM_BITS-1:0], m_tuser);
				error_count++;
			end else begin
				want = pending_scores.pop_front();
				if (m_tdata[SIM_BITS-1:0] !== want.sim) begin
					$error("similarity: expected %0d, got %0d", want.sim,
						m_tdata[SIM_BITS-1:0]);
					error_count++;
				end
				if (m_tuser !== want.degen) begin
					$error("degenerate: expected %0b, got %0b", want.degen, m_tuser);
					error_count++;
				end
			end
		end
	end

	initial begin
		int        random_items;
		int        len;
		pair_row_t row;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		s_tlast  <= 1'b0;
		dot_acc  = '0;
		a_energy = '0;
		b_energy = '0;
		error_count = 0;
		send_steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			offer_pair(directed[i]);

		// A long vector at full scale drives every accumulator far up.
		row = '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 17'd0, 1'b0};
		for (int i = 0; i < 256; i++) begin
			row.last = (i == 255);
			offer_pair(row);
		end

		random_items = 0;
		while (random_items < 520) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 12);
			send_vector(len);
			random_items += len;
		end
		s_tvalid <= 1'b0;

		while (pending_scores.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
sv/csu_pkg.sv
sv/csu_ctrl.sv
sv/csu_datapath.sv
sv/cosine_similarity_unit.sv
sim/cosine_similarity_unit_tb.sv
